/* rtl/stg_pkg.sv */
`timescale 1ns / 1ps
package stg_pkg;

	localparam int PHASE_BITS  = 24;
	localparam int STEP_W      = PHASE_BITS + 2;
	localparam int PERIOD_W    = 11;
	localparam int CLK_HZ_W    = 21;
	localparam int STEP_DIV_W  = 20;
	localparam int DEN_W       = STEP_DIV_W + PERIOD_W + 1;
	localparam int NUM_W       = CLK_HZ_W + PHASE_BITS;
	localparam int CNT_W       = $clog2(STEP_W);
	localparam int SAMPLE_W    = 5;
	localparam int VOLUME_W    = 4;
	localparam int DUTY_W      = 3;

	localparam logic [CLK_HZ_W-1:0]   CPU_CLOCK_HZ = CLK_HZ_W'(1789773);
	localparam logic [STEP_DIV_W-1:0] STEP_DIVISOR = STEP_DIV_W'(705600);
	localparam logic [NUM_W-1:0]      STEP_NUM     = NUM_W'(CPU_CLOCK_HZ) << PHASE_BITS;
	localparam logic [DEN_W-1:0]      REM_INIT     = DEN_W'(STEP_NUM >> STEP_W);
	localparam logic [STEP_W-1:0]     NUM_LOW      = STEP_NUM[STEP_W-1:0];
	localparam logic [CNT_W-1:0]      CNT_LAST     = CNT_W'(STEP_W - 1);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	localparam logic [1:0] REG_CTRL      = 2'd0;
	localparam logic [1:0] REG_SWEEP     = 2'd1;
	localparam logic [1:0] REG_PERIOD_LO = 2'd2;
	localparam logic [1:0] REG_PERIOD_HI = 2'd3;

	typedef struct packed {
		logic load_ctrl;
		logic load_lo;
		logic load_hi;
		logic tick;
		logic mul;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

	function automatic logic [DUTY_W-1:0] duty_lookup(input logic [1:0] sel);
		logic [DUTY_W-1:0] d;
		case (sel)
			2'd0:    d = 3'd1;
			2'd1:    d = 3'd2;
			2'd2:    d = 3'd4;
			2'd3:    d = 3'd6;
			default: d = 3'd1;
		endcase
		return d;
	endfunction

endpackage

/* rtl/stg_in_if.sv */
`timescale 1ns / 1ps
interface stg_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [1:0] reg_offset;
	logic [7:0] write_data;

	modport source (output valid, command, reg_offset, write_data, input ready);
	modport sink   (input valid, command, reg_offset, write_data, output ready);
endinterface

/* rtl/stg_out_if.sv */
`timescale 1ns / 1ps
interface stg_out_if;
	logic              valid;
	logic              ready;
	logic signed [4:0] sample;

	modport source (output valid, sample, input ready);
	modport sink   (input valid, sample, output ready);
endinterface

/* rtl/square_tone_generator.sv */
`timescale 1ns / 1ps
// Pulse tone channel. Each transfer on item is a register write (command 0) or a sample
// tick (command 1); a tick returns one signed sample, +volume or -volume in units of 1/15,
// and a write returns nothing. Ticks and writes to registers 0 and 1 start no division. A
// write to register 2 or 3 recomputes the phase step with a restoring divider that yields
// one quotient bit per cycle, so the block is busy through its multiply, divide and finish
// states and accepts nothing else until the division is done. A tick is taken while the
// previous sample still waits only if that sample is taken in the same cycle.
module square_tone_generator (
	input  logic      clk,
	input  logic      arst_n,
	stg_in_if.sink    item,
	stg_out_if.source audio
);

	stg_pkg::cmd_t cmd;
	stg_pkg::sts_t sts;

	stg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (item.valid),
		.command    (item.command),
		.reg_offset (item.reg_offset),
		.sts        (sts),
		.ready      (item.ready),
		.cmd        (cmd)
	);

	stg_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.write_data (item.write_data),
		.cmd        (cmd),
		.sts        (sts),
		.audio      (audio)
	);

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul || cmd.div_step || cmd.finish) |-> !item.ready)
		else $error("item accepted during step division");

	a_period_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_lo || cmd.load_hi) |=> cmd.mul)
		else $error("period write did not start division");

	a_mul_then_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |=> cmd.div_step)
		else $error("divider did not follow multiply");

	a_tick_gives_sample: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick |=> audio.valid)
		else $error("tick produced no sample");

endmodule

/* rtl/stg_ctrl.sv */
`timescale 1ns / 1ps
module stg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	input  logic              command,
	input  logic [1:0]        reg_offset,
	input  stg_pkg::sts_t     sts,
	output logic              ready,
	output stg_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_FIN
	} state_t;

	state_t                   state_q;
	logic [stg_pkg::CNT_W-1:0] cnt_q;
	logic                     accept;
	logic                     is_write;

	always_comb begin
		ready    = (state_q == S_IDLE) && sts.out_free;
		accept   = valid && ready;
		is_write = accept && (command == stg_pkg::CMD_WRITE);
		cmd.load_ctrl = is_write && (reg_offset == stg_pkg::REG_CTRL);
		cmd.load_lo   = is_write && (reg_offset == stg_pkg::REG_PERIOD_LO);
		cmd.load_hi   = is_write && (reg_offset == stg_pkg::REG_PERIOD_HI);
		cmd.tick      = accept && (command == stg_pkg::CMD_TICK);
		cmd.mul       = (state_q == S_MUL);
		cmd.div_step  = (state_q == S_DIV);
		cmd.finish    = (state_q == S_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load_lo || cmd.load_hi) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_DIV;
					cnt_q   <= stg_pkg::CNT_LAST;
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/stg_datapath.sv */
`timescale 1ns / 1ps
module stg_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    write_data,
	input  stg_pkg::cmd_t cmd,
	output stg_pkg::sts_t sts,
	stg_out_if.source     audio
);

	logic [stg_pkg::DUTY_W-1:0]     duty_q;
	logic [stg_pkg::VOLUME_W-1:0]   volume_q;
	logic [7:0]                     period_lo_q;
	logic [2:0]                     period_hi_q;
	logic [stg_pkg::STEP_W-1:0]     step_q;
	logic [stg_pkg::PHASE_BITS-1:0] phase_q;
	logic [stg_pkg::DEN_W-1:0]      den_q;
	logic [stg_pkg::DEN_W-1:0]      rem_q;
	logic [stg_pkg::STEP_W-1:0]     num_q;
	logic [stg_pkg::STEP_W-1:0]     quot_q;
	logic                           out_valid_q;
	logic signed [stg_pkg::SAMPLE_W-1:0] sample_q;

	logic [stg_pkg::PERIOD_W:0]     period_p1;
	logic [stg_pkg::DEN_W-1:0]      den_prod;
	logic [stg_pkg::DEN_W:0]        trial;
	logic [stg_pkg::DEN_W:0]        trial_diff;
	logic                           q_bit;
	logic                           high_side;
	logic signed [stg_pkg::SAMPLE_W-1:0] level;

	always_comb begin
		period_p1  = {1'b0, period_hi_q, period_lo_q} + 1'b1;
		den_prod   = {{(stg_pkg::DEN_W - stg_pkg::STEP_DIV_W){1'b0}}, stg_pkg::STEP_DIVISOR}
			* {{(stg_pkg::DEN_W - stg_pkg::PERIOD_W - 1){1'b0}}, period_p1};
		trial      = {rem_q, num_q[stg_pkg::STEP_W-1]};
		trial_diff = trial - {1'b0, den_q};
		q_bit      = !trial_diff[stg_pkg::DEN_W];
		high_side  = phase_q[stg_pkg::PHASE_BITS-1 -: stg_pkg::DUTY_W] < duty_q;
		level      = $signed({1'b0, volume_q});
		sts.out_free = !out_valid_q || audio.ready;
	end

	assign audio.valid  = out_valid_q;
	assign audio.sample = sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q      <= '0;
			volume_q    <= '0;
			period_lo_q <= '0;
			period_hi_q <= '0;
			step_q      <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_ctrl) begin
				duty_q   <= stg_pkg::duty_lookup(write_data[7:6]);
				volume_q <= write_data[3:0];
			end
			if (cmd.load_lo) begin
				period_lo_q <= write_data;
			end
			if (cmd.load_hi) begin
				period_hi_q <= write_data[2:0];
			end
			if (cmd.finish) begin
				step_q <= quot_q;
			end
			if (cmd.tick) begin
				phase_q     <= phase_q + step_q[stg_pkg::PHASE_BITS-1:0];
				out_valid_q <= 1'b1;
			end else if (audio.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			sample_q <= high_side ? level : -level;
		end
		if (cmd.mul) begin
			den_q  <= den_prod;
			rem_q  <= stg_pkg::REM_INIT;
			num_q  <= stg_pkg::NUM_LOW;
			quot_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= q_bit ? trial_diff[stg_pkg::DEN_W-1:0] : trial[stg_pkg::DEN_W-1:0];
			num_q  <= {num_q[stg_pkg::STEP_W-2:0], 1'b0};
			quot_q <= {quot_q[stg_pkg::STEP_W-2:0], q_bit};
		end
	end

endmodule
